// File: src/bkeq_pkg.sv
`default_nettype none

package bkeq_pkg;

  // address field wide enough for the largest queue
  localparam int ADDR_W = 8;

  localparam logic REQ_BUTTON = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_OK   = 2'd2;

  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_RELEASED = 2'd1;

  localparam logic [1:0] KEY_UP    = 2'd0;
  localparam logic [1:0] KEY_DOWN  = 2'd1;
  localparam logic [1:0] KEY_ENTER = 2'd2;
  localparam logic [1:0] KEY_BACK  = 2'd3;

  localparam logic [15:0] THRESHOLD_RESET = 16'd800;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  button_id;
    logic [1:0]  button_event;
    logic [31:0] time_ms;
  } req_t;

  typedef struct packed {
    logic       updated;
    logic       key_pressed;
    logic [1:0] key_code;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage

`default_nettype wire

// File: src/bkeq_key_ram.sv
`default_nettype none

module bkeq_key_ram import bkeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire ram_req_t ram_req,
  output logic [1:0]    rdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      mem[ram_req.waddr[PTR_W-1:0]] <= ram_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_req.re) begin
      rdata <= mem[ram_req.raddr[PTR_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// File: src/bkeq_ctrl.sv
`default_nettype none

module bkeq_ctrl import bkeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] threshold,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req_data,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp_data,
  output ram_req_t         ram_req,
  input  wire logic [1:0]  ram_rdata
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W:0]   DEPTH_S  = (PTR_W+1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  state_t           state, state_next;
  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [31:0]      ok_press_time;
  logic [1:0]       held_key;
  logic             key_is_held;

  logic             out_free;
  logic             accept;
  logic [31:0]      held_ms;
  logic             long_press;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] slot;
  logic [PTR_W-1:0] head_inc;
  logic             fifo_full;
  logic             fifo_empty;

  logic             push_en;
  logic [1:0]       push_code;
  logic             pop_en;
  logic             ok_store;
  logic             release_key;
  logic             load_rsp;
  rsp_t             rsp_load;

  assign out_free   = !rsp_valid || rsp_ready;
  assign accept     = req_valid && req_ready;
  assign held_ms    = req_data.time_ms - ok_press_time;
  assign long_press = held_ms >= {16'd0, threshold};
  assign fifo_full  = count == DEPTH_C;
  assign fifo_empty = count == '0;

  // tail slot wraps at the queue depth, sum stays below twice the depth
  assign slot_sum = {1'b0, head} + (PTR_W+1)'(count);
  assign slot     = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S) : slot_sum[PTR_W-1:0];
  assign head_inc = (head == LAST_PTR) ? '0 : head + PTR_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_data.req_type == REQ_POLL && !key_is_held && !fifo_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    push_en     = 1'b0;
    push_code   = KEY_UP;
    pop_en      = 1'b0;
    ok_store    = 1'b0;
    release_key = 1'b0;
    load_rsp    = 1'b0;
    rsp_load    = '0;
    case (state)
      ST_IDLE: begin
        req_ready = out_free;
        if (accept) begin
          if (req_data.req_type == REQ_POLL) begin
            if (!key_is_held && !fifo_empty) begin
              pop_en = 1'b1;
            end else begin
              load_rsp = 1'b1;
              if (key_is_held) begin
                release_key          = 1'b1;
                rsp_load.updated     = 1'b1;
                rsp_load.key_pressed = 1'b0;
                rsp_load.key_code    = held_key;
              end
            end
          end else begin
            case (req_data.button_id)
              BTN_UP: begin
                push_en   = req_data.button_event == EV_PRESSED;
                push_code = KEY_UP;
              end
              BTN_DOWN: begin
                push_en   = req_data.button_event == EV_PRESSED;
                push_code = KEY_DOWN;
              end
              BTN_OK: begin
                ok_store  = req_data.button_event == EV_PRESSED;
                push_en   = req_data.button_event == EV_RELEASED;
                push_code = long_press ? KEY_BACK : KEY_ENTER;
              end
              default: push_en = 1'b0;
            endcase
          end
        end
      end
      ST_READ: begin
        // popped key arrives from the ram in the cycle after the read
        load_rsp             = 1'b1;
        rsp_load.updated     = 1'b1;
        rsp_load.key_pressed = 1'b1;
        rsp_load.key_code    = ram_rdata;
      end
      default: req_ready = 1'b0;
    endcase
  end

  always_comb begin
    ram_req       = '0;
    ram_req.we    = push_en && !fifo_full;
    ram_req.waddr = ADDR_W'(slot);
    ram_req.wdata = push_code;
    ram_req.re    = pop_en;
    ram_req.raddr = ADDR_W'(head);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      count         <= '0;
      ok_press_time <= '0;
      held_key      <= KEY_UP;
      key_is_held   <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (push_en && !fifo_full) begin
        count <= count + CNT_W'(1);
      end else if (pop_en) begin
        count <= count - CNT_W'(1);
        head  <= head_inc;
      end
      if (ok_store) begin
        ok_press_time <= req_data.time_ms;
      end
      if (pop_en) begin
        key_is_held <= 1'b1;
      end else if (release_key) begin
        key_is_held <= 1'b0;
      end
      if (state == ST_READ) begin
        held_key <= ram_rdata;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_data <= rsp_load;
    end
  end

endmodule

`default_nettype wire

// File: src/button_key_event_queue_unit.sv
// button events give no response
// a poll answers in the cycle after acceptance, or after the ram read and ST_READ when a key is popped from the ram
// a pop holds off the request channel while the ram read completes
// a request is taken only while the response register is empty or being drained
// synchronous reset empties the queue, clears the held key, threshold back to 800 ms
`default_nettype none

module button_key_event_queue_unit import bkeq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_ready,
  input  wire req_t        req_data,
  output logic             rsp_valid,
  input  wire logic        rsp_ready,
  output rsp_t             rsp_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic [15:0] threshold;
  ram_req_t    ram_req;
  logic [1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  bkeq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  bkeq_key_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );

endmodule

`default_nettype wire

// File: src/bkeq_checker.sv
`default_nettype none

module bkeq_checker import bkeq_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire req_t        req_data,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire rsp_t        rsp_data
);

  // no response is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed");

  // button requests never produce a response
  a_button_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.req_type == REQ_BUTTON && !rsp_valid |=> !rsp_valid)
    else $error("response after button request");

  a_no_update_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.updated |-> !rsp_data.key_pressed && rsp_data.key_code == KEY_UP)
    else $error("empty poll response carries key data");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while response stalled");

endmodule

bind button_key_event_queue_unit bkeq_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

`default_nettype wire

// File: sim/tb_button_key_event_queue_unit.sv
`default_nettype none

module tb_button_key_event_queue_unit;
  import bkeq_pkg::*;

  localparam int DEPTH = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  button_key_event_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_reqs[$];
  rsp_t due_reports[$];

  // shadow of the key queue and its bookkeeping
  logic [1:0]  model_keys[$];
  logic [31:0] model_ok_time = '0;
  logic [1:0]  model_held_key = KEY_UP;
  logic        model_key_held = 1'b0;
  logic [15:0] model_threshold = THRESHOLD_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic void queue_key(input logic [1:0] code);
    if (model_keys.size() < DEPTH) model_keys.push_back(code);
  endfunction

  function automatic void predict_key_report(input req_t r);
    rsp_t rep;
    logic [31:0] held_ms;
    if (r.req_type == REQ_BUTTON) begin
      case (r.button_id)
        BTN_UP: begin
          if (r.button_event == EV_PRESSED) queue_key(KEY_UP);
        end
        BTN_DOWN: begin
          if (r.button_event == EV_PRESSED) queue_key(KEY_DOWN);
        end
        BTN_OK: begin
          if (r.button_event == EV_PRESSED) begin
            model_ok_time = r.time_ms;
          end else if (r.button_event == EV_RELEASED) begin
            held_ms = r.time_ms - model_ok_time;
            queue_key(held_ms < {16'd0, model_threshold} ? KEY_ENTER : KEY_BACK);
          end
        end
        default: ;
      endcase
    end else begin
      rep = '0;
      if (!model_key_held && model_keys.size() != 0) begin
        model_held_key = model_keys.pop_front();
        model_key_held = 1'b1;
        rep = '{1'b1, 1'b1, model_held_key};
      end else if (model_key_held) begin
        // second poll reports the same key as released
        model_key_held = 1'b0;
        rep = '{1'b1, 1'b0, model_held_key};
      end
      due_reports.push_back(rep);
    end
  endfunction

  function automatic req_t button_req(input logic [1:0] id, input logic [1:0] ev,
                                      input logic [31:0] t);
    req_t r;
    r.req_type = REQ_BUTTON;
    r.button_id = id;
    r.button_event = ev;
    r.time_ms = t;
    return r;
  endfunction

  function automatic req_t poll_req();
    req_t r;
    r = button_req(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom());
    r.req_type = REQ_POLL;
    return r;
  endfunction

  // mostly well-formed key traffic, with fill and drain bursts and some noise
  task automatic add_key_traffic(input int n);
    int added;
    int pick;
    int len;
    int thr;
    logic [31:0] t0;
    logic [31:0] hold;
    added = 0;
    thr = int'(model_threshold);
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        pending_reqs.push_back(poll_req());
        added++;
      end else if (pick < 50) begin
        pending_reqs.push_back(button_req($urandom_range(1) ? BTN_DOWN : BTN_UP,
                                          EV_PRESSED, $urandom()));
        added++;
      end else if (pick < 70) begin
        case ($urandom_range(5))
          0: hold = {16'd0, model_threshold} - 32'd1;
          1: hold = {16'd0, model_threshold};
          2: hold = {16'd0, model_threshold} + 32'd1;
          3: hold = $urandom_range(2 * thr + 2);
          4: hold = $urandom();
          default: hold = '0;
        endcase
        t0 = $urandom();
        if ($urandom_range(3) == 0) t0 = 32'hFFFF_FFFF - $urandom_range(2000);
        pending_reqs.push_back(button_req(BTN_OK, EV_PRESSED, t0));
        if ($urandom_range(3) == 0) begin
          pending_reqs.push_back(poll_req());
          added++;
        end
        pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, t0 + hold));
        added += 2;
      end else if (pick < 74) begin
        // overrun the queue so the extra keys get dropped
        len = $urandom_range(DEPTH + 4, DEPTH + 1);
        repeat (len) begin
          pending_reqs.push_back(button_req(2'($urandom_range(1)), EV_PRESSED, $urandom()));
        end
        added += len;
      end else if (pick < 80) begin
        len = $urandom_range(2 * DEPTH + 4, 4);
        repeat (len) pending_reqs.push_back(poll_req());
        added += len;
      end else if (pick < 86) begin
        pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, $urandom()));
        added++;
      end else begin
        pending_reqs.push_back(button_req(2'($urandom_range(3)), 2'($urandom_range(3)),
                                          $urandom()));
        added++;
      end
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || due_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] thr, input int idle_pct, input int stall_pct,
                           input int n_items, input bit long_hold);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    model_threshold = thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    add_key_traffic(n_items);
    if (long_hold) hold_cycles_left = LONG_HOLD;
    wait_until_drained();
  endtask

  always @(posedge clk) begin : req_side
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) predict_key_report(req_data);
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_data <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_side
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report with no poll waiting: upd=%0b prs=%0b key=%0d",
                     rsp_data.updated, rsp_data.key_pressed, rsp_data.key_code);
        end else begin
          want = due_reports.pop_front();
          if (rsp_data.updated !== want.updated || rsp_data.key_pressed !== want.key_pressed ||
              rsp_data.key_code !== want.key_code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected upd=%0b prs=%0b key=%0d, got upd=%0b prs=%0b key=%0d",
                       want.updated, want.key_pressed, want.key_code,
                       rsp_data.updated, rsp_data.key_pressed, rsp_data.key_code);
          end
        end
      end
      rsp_ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into the request side
  always @(posedge clk) begin
    if (hold_cycles_left > 0) hold_cycles_left <= hold_cycles_left - 1;
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // threshold still at its reset value here
    pending_reqs.push_back(poll_req());
    pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, 32'd799));
    pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, 32'd800));
    pending_reqs.push_back(poll_req());
    pending_reqs.push_back(poll_req());
    pending_reqs.push_back(button_req(BTN_UP, EV_PRESSED, 32'd0));
    pending_reqs.push_back(button_req(BTN_DOWN, EV_PRESSED, 32'hFFFF_FFFF));
    // hold time wraps across zero
    pending_reqs.push_back(button_req(BTN_OK, EV_PRESSED, 32'hFFFF_FF00));
    pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, 32'h0000_021F));
    pending_reqs.push_back(button_req(BTN_OK, EV_PRESSED, 32'h1234_5678));
    pending_reqs.push_back(button_req(BTN_OK, EV_RELEASED, 32'h1234_5678 + 32'd800));
    pending_reqs.push_back(button_req(2'd3, EV_PRESSED, $urandom()));
    pending_reqs.push_back(button_req(BTN_UP, EV_RELEASED, $urandom()));
    pending_reqs.push_back(button_req(BTN_DOWN, EV_RELEASED, $urandom()));
    pending_reqs.push_back(button_req(BTN_OK, 2'd2, $urandom()));
    pending_reqs.push_back(button_req(BTN_OK, 2'd3, $urandom()));
    repeat (11) pending_reqs.push_back(poll_req());
    wait_until_drained();

    run_phase(16'd1, 0, 0, 130, 1'b0);
    run_phase(16'hFFFF, 85, 0, 120, 1'b0);
    run_phase(16'd0, 0, 85, 100, 1'b1);
    run_phase(16'($urandom_range(65535, 1)), 8, 8, 170, 1'b1);
    run_phase(16'($urandom_range(2000, 1)), 0, 0, 200, 1'b0);

    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
